### rtl/core/i2cra_pkg.sv
// Shared types, codes and the transaction program of the I2C register master.
// Used by i2cra_front, i2cra_back and i2c_register_access_master_unit.
package i2cra_pkg;

    // Input selector codes.
    localparam logic [1:0] FUNC_TICK  = 2'd0;
    localparam logic [1:0] FUNC_WRITE = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    localparam logic [7:0] DEV_ADDR_RESET = 8'h80;
    localparam logic [7:0] READ_BIT       = 8'h01;

    // Queue between the front and the back; two entries keep one word per cycle while the output is not stalled.
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int PHASE_W = 7;
    localparam int SEG_W   = 5;
    localparam int SUB_W   = 2;
    localparam logic [SEG_W-1:0] SEG_MAX = 5'd31;

    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    // Classified input word as it sits in the queue.
    typedef struct packed {
        cmd_t        cmd;
        logic [7:0]  reg_addr;
        logic [15:0] write_data;
        logic        sda_in;
    } q_word_t;

    typedef enum logic [2:0] {
        K_START = 3'd0,
        K_WBYTE = 3'd1,
        K_ACK   = 3'd2,
        K_RBYTE = 3'd3,
        K_MACK  = 3'd4,
        K_MNACK = 3'd5,
        K_STOP  = 3'd6
    } kind_t;

    typedef enum logic [2:0] {
        SRC_DEV  = 3'd0,
        SRC_DEVR = 3'd1,
        SRC_REG  = 3'd2,
        SRC_HI   = 3'd3,
        SRC_LO   = 3'd4
    } src_t;

    typedef struct packed {
        kind_t kind;
        src_t  src;
    } prog_ent_t;

    // Program entry for a 1-based segment; a stop outside the program.
    function automatic prog_ent_t prog_entry(input logic [SEG_W-1:0] seg, input logic is_read);
        prog_ent_t e;
        e = '{kind: K_STOP, src: SRC_DEV};
        if (is_read) begin
            case (seg)
                5'd1:    e = '{kind: K_START, src: SRC_DEV};
                5'd2:    e = '{kind: K_WBYTE, src: SRC_DEV};
                5'd3:    e = '{kind: K_ACK,   src: SRC_DEV};
                5'd4:    e = '{kind: K_WBYTE, src: SRC_REG};
                5'd5:    e = '{kind: K_ACK,   src: SRC_DEV};
                5'd6:    e = '{kind: K_START, src: SRC_DEV};
                5'd7:    e = '{kind: K_WBYTE, src: SRC_DEVR};
                5'd8:    e = '{kind: K_ACK,   src: SRC_DEV};
                5'd9:    e = '{kind: K_RBYTE, src: SRC_DEV};
                5'd10:   e = '{kind: K_MACK,  src: SRC_DEV};
                5'd11:   e = '{kind: K_RBYTE, src: SRC_DEV};
                5'd12:   e = '{kind: K_MNACK, src: SRC_DEV};
                default: e = '{kind: K_STOP,  src: SRC_DEV};
            endcase
        end else begin
            case (seg)
                5'd1:    e = '{kind: K_START, src: SRC_DEV};
                5'd2:    e = '{kind: K_WBYTE, src: SRC_DEV};
                5'd3:    e = '{kind: K_ACK,   src: SRC_DEV};
                5'd4:    e = '{kind: K_WBYTE, src: SRC_REG};
                5'd5:    e = '{kind: K_ACK,   src: SRC_DEV};
                5'd6:    e = '{kind: K_WBYTE, src: SRC_HI};
                5'd7:    e = '{kind: K_ACK,   src: SRC_DEV};
                5'd8:    e = '{kind: K_WBYTE, src: SRC_LO};
                5'd9:    e = '{kind: K_ACK,   src: SRC_DEV};
                default: e = '{kind: K_STOP,  src: SRC_DEV};
            endcase
        end
        return e;
    endfunction

endpackage

### rtl/core/i2cra_front.sv
// Input side of the I2C register master: accept, classify, and queue words.
// Depends on i2cra_pkg.
module i2cra_front #(
    parameter int QUEUE_DEPTH = i2cra_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [7:0]         reg_addr,
    input  logic [15:0]        write_data,
    input  logic               sda_in,
    output logic               q_valid,
    output i2cra_pkg::q_word_t q_word,
    input  logic               q_pop
);
    import i2cra_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_word_t          queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    q_word_t          new_word;

    // Classify: unknown selector codes count as plain ticks.
    always_comb
    begin
        new_word.reg_addr   = reg_addr;
        new_word.write_data = write_data;
        new_word.sda_in     = sda_in;
        case (func)
            FUNC_WRITE: new_word.cmd = CMD_WRITE;
            FUNC_READ:  new_word.cmd = CMD_READ;
            default:    new_word.cmd = CMD_TICK;
        endcase
    end

    assign in_stall = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign q_word   = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : PTR_W'(wr_ptr_reg + 1'b1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                        : PTR_W'(rd_ptr_reg + 1'b1);
        end
        count_next = CNT_W'(count_reg + CNT_W'(push) - CNT_W'(q_pop));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= new_word;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> count_reg != '0)
        else $error("queue popped while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count above depth");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        push && !q_pop |=> count_reg == CNT_W'($past(count_reg) + 1'b1))
        else $error("queue count lost a push");

endmodule

### rtl/core/i2cra_back.sv
// Pin sequencer of the I2C register master: one pin step per queued word,
// result held in an output register. Depends on i2cra_pkg.
module i2cra_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  i2cra_pkg::q_word_t q_word,
    output logic               q_pop,
    input  logic [7:0]         device_address,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               scl,
    output logic               sda_out,
    output logic               sda_drive,
    output logic               busy_res,
    output logic               done_res,
    output logic [15:0]        read_data
);
    import i2cra_pkg::*;

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [2:0]         bitc_reg, bitc_next;
    logic [7:0]         shift_reg, shift_next;
    logic               rd_reg, rd_next;
    logic [7:0]         hreg_reg, hreg_next;
    logic [15:0]        hdata_reg, hdata_next;
    logic [15:0]        rword_reg, rword_next;
    logic               scl_reg, scl_next;
    logic               sda_reg, sda_next;
    logic               drv_reg, drv_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [15:0]        rdata_reg, rdata_next;
    logic               oval_reg;

    logic [SEG_W-1:0]   seg, nseg;
    logic [SUB_W-1:0]   sub;
    prog_ent_t          ent, nent;
    logic               adv, keep;
    logic [SEG_W:0]     seg_inc;

    assign q_pop = q_valid && (!oval_reg || !out_stall);

    always_comb
    begin
        phase_next = phase_reg;
        bitc_next  = bitc_reg;
        shift_next = shift_reg;
        rd_next    = rd_reg;
        hreg_next  = hreg_reg;
        hdata_next = hdata_reg;
        rword_next = rword_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        drv_next   = drv_reg;
        done_next  = 1'b0;
        adv        = 1'b0;
        keep       = 1'b0;
        seg_inc    = '0;
        nseg       = '0;
        nent       = '{kind: K_STOP, src: SRC_DEV};

        // Take a command only when idle; it begins with the first start step.
        if (phase_reg == '0 && q_word.cmd != CMD_TICK)
        begin
            rd_next    = (q_word.cmd == CMD_READ);
            hreg_next  = q_word.reg_addr;
            hdata_next = q_word.write_data;
            phase_next = {SEG_W'(1), SUB_W'(0)};
            bitc_next  = '0;
        end

        seg = phase_next[PHASE_W-1:SUB_W];
        sub = phase_next[SUB_W-1:0];
        ent = prog_entry(seg, rd_next);

        if (phase_next != '0)
        begin
            case (ent.kind)
                K_START:
                begin
                    case (sub)
                        2'd0:
                        begin
                            drv_next = 1'b1;
                            sda_next = 1'b1;
                        end
                        2'd1:    scl_next = 1'b1;
                        2'd2:    sda_next = 1'b0;
                        default:
                        begin
                            scl_next = 1'b0;
                            adv      = 1'b1;
                        end
                    endcase
                end
                K_WBYTE:
                begin
                    if (sub == 2'd0)
                    begin
                        drv_next = 1'b1;
                        sda_next = shift_next[7];
                    end
                    else if (sub == 2'd1)
                    begin
                        scl_next   = 1'b1;
                        shift_next = {shift_next[6:0], 1'b0};
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        if (bitc_next == 3'd7)
                        begin
                            adv = 1'b1;
                        end
                        else
                        begin
                            bitc_next  = 3'(bitc_next + 1'b1);
                            phase_next = {seg, SUB_W'(0)};
                            keep       = 1'b1;
                        end
                    end
                end
                K_ACK:
                begin
                    // Slave ack level is not checked.
                    if (sub == 2'd0)
                    begin
                        drv_next = 1'b0;
                        sda_next = 1'b1;
                    end
                    else if (sub == 2'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        adv      = 1'b1;
                    end
                end
                K_RBYTE:
                begin
                    if (sub == 2'd0)
                    begin
                        drv_next   = 1'b0;
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        shift_next = {shift_next[6:0], q_word.sda_in};
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        if (bitc_next == 3'd7)
                        begin
                            rword_next = {rword_reg[7:0], shift_next};
                            adv        = 1'b1;
                        end
                        else
                        begin
                            bitc_next  = 3'(bitc_next + 1'b1);
                            phase_next = {seg, SUB_W'(0)};
                            keep       = 1'b1;
                        end
                    end
                end
                K_MACK, K_MNACK:
                begin
                    if (sub == 2'd0)
                    begin
                        drv_next = 1'b1;
                        sda_next = (ent.kind == K_MNACK);
                    end
                    else if (sub == 2'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        scl_next = 1'b0;
                        adv      = 1'b1;
                    end
                end
                default:
                begin
                    // Stop condition: data low, clock high, data high.
                    if (sub == 2'd0)
                    begin
                        drv_next = 1'b1;
                        sda_next = 1'b0;
                    end
                    else if (sub == 2'd1)
                    begin
                        scl_next = 1'b1;
                    end
                    else
                    begin
                        sda_next   = 1'b1;
                        phase_next = '0;
                        bitc_next  = '0;
                        done_next  = 1'b1;
                        keep       = 1'b1;
                    end
                end
            endcase

            if (adv)
            begin
                // Enter the next segment and load its byte.
                seg_inc    = (SEG_W + 1)'(seg) + 1'b1;
                nseg       = (seg_inc > (SEG_W + 1)'(SEG_MAX)) ? SEG_MAX : seg_inc[SEG_W-1:0];
                phase_next = {nseg, SUB_W'(0)};
                bitc_next  = '0;
                nent       = prog_entry(nseg, rd_next);
                if (nent.kind == K_WBYTE)
                begin
                    case (nent.src)
                        SRC_DEV:  shift_next = device_address;
                        SRC_DEVR: shift_next = device_address | READ_BIT;
                        SRC_REG:  shift_next = hreg_next;
                        SRC_HI:   shift_next = hdata_next[15:8];
                        default:  shift_next = hdata_next[7:0];
                    endcase
                end
                else if (nent.kind == K_RBYTE)
                begin
                    shift_next = '0;
                end
            end
            else if (!keep)
            begin
                phase_next = PHASE_W'(phase_next + 1'b1);
            end
        end

        busy_next  = (phase_next != '0);
        rdata_next = (done_next && rd_next) ? rword_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            bitc_reg  <= '0;
            shift_reg <= '0;
            rd_reg    <= 1'b0;
            hreg_reg  <= '0;
            hdata_reg <= '0;
            rword_reg <= '0;
            scl_reg   <= 1'b1;
            sda_reg   <= 1'b1;
            drv_reg   <= 1'b1;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            rdata_reg <= '0;
            oval_reg  <= 1'b0;
        end
        else if (q_pop)
        begin
            phase_reg <= phase_next;
            bitc_reg  <= bitc_next;
            shift_reg <= shift_next;
            rd_reg    <= rd_next;
            hreg_reg  <= hreg_next;
            hdata_reg <= hdata_next;
            rword_reg <= rword_next;
            scl_reg   <= scl_next;
            sda_reg   <= sda_next;
            drv_reg   <= drv_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            rdata_reg <= rdata_next;
            oval_reg  <= 1'b1;
        end
        else if (!out_stall)
        begin
            oval_reg <= 1'b0;
        end
    end

    assign out_valid = oval_reg;
    assign scl       = scl_reg;
    assign sda_out   = sda_reg;
    assign sda_drive = drv_reg;
    assign busy_res  = busy_reg;
    assign done_res  = done_reg;
    assign read_data = rdata_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        oval_reg && done_reg |-> !busy_reg && phase_reg == '0)
        else $error("done reported while sequencer still busy");

    a_done_lines: assert property (@(posedge clk) disable iff (!rst_n)
        oval_reg && done_reg |-> scl_reg && sda_reg && drv_reg)
        else $error("bus not left in stop state after done");

    a_rdata_zero: assert property (@(posedge clk) disable iff (!rst_n)
        oval_reg && !done_reg |-> rdata_reg == '0)
        else $error("read data shown outside a done step");

    a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (phase_reg != '0))
        else $error("busy flag out of step with sequencer phase");

endmodule

### rtl/core/i2c_register_access_master_unit.sv
// Top level of the I2C register master: device address register, front queue
// and pin sequencer. Depends on i2cra_pkg, i2cra_front and i2cra_back.

// I2C master for 16-bit register transactions, driven one pin step per input
// word. A word with func = write (1) or read (2) on an idle bus starts a
// transaction and performs its first step at once; every later word, whatever
// its func, advances the bus by exactly one step (commands while busy are
// dropped). Each accepted word yields exactly one result word carrying the
// scl, sda_out and sda_drive levels after that step, busy_res, a done_res
// pulse at the final stop step, and read_data (the word read, high byte
// first) on the done step of a read, zero otherwise. Slave ack bits are not
// checked. sda_in is sampled on read-bit steps. The device address register
// resets to 0x80; write it only while no word is in flight (queue and output
// register empty). A new address takes effect at the next address byte, even
// mid-transaction. The read phase sends it with bit 0 set. Throughput is one
// word per clock cycle sustained while out_stall is low: the pin sequencer
// finishes one step per cycle. Each word passes from input accept to output
// valid through the front queue and then the sequencer's output register.
// The front queue (QUEUE_DEPTH entries, at least 2) lets input accepts
// continue while a result waits on out_stall.
module i2c_register_access_master_unit #(
    parameter int QUEUE_DEPTH = i2cra_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    // input words
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  reg_addr,
    input  logic [15:0] write_data,
    input  logic        sda_in,
    // result words
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl,
    output logic        sda_out,
    output logic        sda_drive,
    output logic        busy_res,
    output logic        done_res,
    output logic [15:0] read_data
);
    import i2cra_pkg::*;

    logic [7:0] dev_addr_reg;
    q_word_t    q_word;
    logic       q_valid;
    logic       q_pop;

    // Hold the device address byte; read-bit forcing happens in the sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg <= DEV_ADDR_RESET;
        end
        else if (cfg_write_en)
        begin
            dev_addr_reg <= cfg_write_data;
        end
    end

    // Accept and classify input words into a short queue.
    i2cra_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .reg_addr   (reg_addr),
        .write_data (write_data),
        .sda_in     (sda_in),
        .q_valid    (q_valid),
        .q_word     (q_word),
        .q_pop      (q_pop)
    );

    // Advance the bus sequencer one step per queued word.
    i2cra_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_word         (q_word),
        .q_pop          (q_pop),
        .device_address (dev_addr_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .scl            (scl),
        .sda_out        (sda_out),
        .sda_drive      (sda_drive),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .read_data      (read_data)
    );

    a_cfg_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_write_en |=> dev_addr_reg == $past(cfg_write_data))
        else $error("device address write lost");

    a_cfg_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_write_en |=> $stable(dev_addr_reg))
        else $error("device address changed without a write");

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop && !busy_res && q_word.cmd != CMD_TICK && (!out_valid || !out_stall)
        |=> busy_res)
        else $error("command on idle bus did not start a transaction");

endmodule

### verif/i2cra_pin_checker.sv
// Pin-level checker for the I2C register master: predicts every result word
// from the accepted input words and compares it field by field.
// Depends on i2cra_pkg; instantiated by tb beside the block.
module i2cra_pin_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  func,
    input  logic [7:0]  reg_addr,
    input  logic [15:0] write_data,
    input  logic        sda_in,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic        scl,
    input  logic        sda_out,
    input  logic        sda_drive,
    input  logic        busy_res,
    input  logic        done_res,
    input  logic [15:0] read_data,
    output int          fail_count
);
    import i2cra_pkg::*;

    typedef struct packed {
        logic        scl;
        logic        sda_out;
        logic        sda_drive;
        logic        busy;
        logic        done;
        logic [15:0] rdata;
    } pin_word_t;

    localparam int WR_SEGS = 10;
    localparam int RD_SEGS = 13;

    localparam kind_t WR_KIND [WR_SEGS] = '{K_START, K_WBYTE, K_ACK, K_WBYTE, K_ACK,
                                            K_WBYTE, K_ACK, K_WBYTE, K_ACK, K_STOP};
    localparam src_t  WR_SRC  [WR_SEGS] = '{SRC_DEV, SRC_DEV, SRC_DEV, SRC_REG, SRC_DEV,
                                            SRC_HI, SRC_DEV, SRC_LO, SRC_DEV, SRC_DEV};
    localparam kind_t RD_KIND [RD_SEGS] = '{K_START, K_WBYTE, K_ACK, K_WBYTE, K_ACK,
                                            K_START, K_WBYTE, K_ACK, K_RBYTE, K_MACK,
                                            K_RBYTE, K_MNACK, K_STOP};
    localparam src_t  RD_SRC  [RD_SEGS] = '{SRC_DEV, SRC_DEV, SRC_DEV, SRC_REG, SRC_DEV,
                                            SRC_DEV, SRC_DEVR, SRC_DEV, SRC_DEV, SRC_DEV,
                                            SRC_DEV, SRC_DEV, SRC_DEV};

    pin_word_t   expected_pins[$];
    pin_word_t   predicted;
    pin_word_t   want;
    pin_word_t   got;

    logic [7:0]  dev_addr;
    logic [6:0]  phase;
    logic [2:0]  bit_idx;
    logic [7:0]  shreg;
    logic        is_read;
    logic [7:0]  reg_latch;
    logic [15:0] data_latch;
    logic [15:0] read_acc;
    logic        line_scl;
    logic        line_sda;
    logic        line_drv;

    // Anything past the end of the program is a stop.
    function automatic void segment_plan(input int seg, output kind_t kind, output src_t src);
        kind = K_STOP;
        src  = SRC_DEV;
        if (seg >= 1 && is_read && seg <= RD_SEGS) begin
            kind = RD_KIND[seg-1];
            src  = RD_SRC[seg-1];
        end else if (seg >= 1 && !is_read && seg <= WR_SEGS) begin
            kind = WR_KIND[seg-1];
            src  = WR_SRC[seg-1];
        end
    endfunction

    // The address register is read here, so a change lands at the next address byte.
    task automatic load_segment(input int seg);
        kind_t kind;
        src_t  src;
        if (seg > 31)
            seg = 31;
        segment_plan(seg, kind, src);
        phase   = 7'(seg << 2);
        bit_idx = '0;
        if (kind == K_WBYTE) begin
            case (src)
                SRC_DEV:  shreg = dev_addr;
                SRC_DEVR: shreg = dev_addr | READ_BIT;
                SRC_REG:  shreg = reg_latch;
                SRC_HI:   shreg = data_latch[15:8];
                default:  shreg = data_latch[7:0];
            endcase
        end else if (kind == K_RBYTE) begin
            shreg = '0;
        end
    endtask

    task automatic predict_pin_step(input logic [1:0] f, input logic [7:0] ra,
                                    input logic [15:0] wd, input logic sd,
                                    output pin_word_t res);
        int         seg;
        logic [1:0] sub;
        kind_t      kind;
        src_t       src;
        logic       advance_seg;
        logic       phase_set;
        logic       finished;
        finished = 1'b0;
        if (phase == '0 && (f == FUNC_WRITE || f == FUNC_READ)) begin
            is_read    = (f == FUNC_READ);
            reg_latch  = ra;
            data_latch = wd;
            load_segment(1);
        end
        if (phase != '0) begin
            seg         = int'(phase[6:2]);
            sub         = phase[1:0];
            advance_seg = 1'b0;
            phase_set   = 1'b0;
            segment_plan(seg, kind, src);
            case (kind)
                K_START: begin
                    case (sub)
                        2'd0: begin line_drv = 1'b1; line_sda = 1'b1; end
                        2'd1: line_scl = 1'b1;
                        2'd2: line_sda = 1'b0;
                        default: begin line_scl = 1'b0; advance_seg = 1'b1; end
                    endcase
                end
                K_WBYTE: begin
                    if (sub == 2'd0) begin
                        line_drv = 1'b1;
                        line_sda = shreg[7];
                    end else if (sub == 2'd1) begin
                        line_scl = 1'b1;
                        shreg    = {shreg[6:0], 1'b0};
                    end else begin
                        line_scl = 1'b0;
                        if (bit_idx == 3'd7) begin
                            advance_seg = 1'b1;
                        end else begin
                            bit_idx   = bit_idx + 3'd1;
                            phase     = 7'(seg << 2);
                            phase_set = 1'b1;
                        end
                    end
                end
                K_ACK: begin
                    // slave ack is never sampled or acted on
                    if (sub == 2'd0) begin
                        line_drv = 1'b0;
                        line_sda = 1'b1;
                    end else if (sub == 2'd1) begin
                        line_scl = 1'b1;
                    end else begin
                        line_scl    = 1'b0;
                        advance_seg = 1'b1;
                    end
                end
                K_RBYTE: begin
                    if (sub == 2'd0) begin
                        line_drv = 1'b0;
                        line_sda = 1'b1;
                        line_scl = 1'b1;
                        shreg    = {shreg[6:0], sd};
                    end else begin
                        line_scl = 1'b0;
                        if (bit_idx == 3'd7) begin
                            read_acc    = {read_acc[7:0], shreg};
                            advance_seg = 1'b1;
                        end else begin
                            bit_idx   = bit_idx + 3'd1;
                            phase     = 7'(seg << 2);
                            phase_set = 1'b1;
                        end
                    end
                end
                K_MACK, K_MNACK: begin
                    if (sub == 2'd0) begin
                        line_drv = 1'b1;
                        line_sda = (kind == K_MNACK);
                    end else if (sub == 2'd1) begin
                        line_scl = 1'b1;
                    end else begin
                        line_scl    = 1'b0;
                        advance_seg = 1'b1;
                    end
                end
                default: begin
                    if (sub == 2'd0) begin
                        line_drv = 1'b1;
                        line_sda = 1'b0;
                    end else if (sub == 2'd1) begin
                        line_scl = 1'b1;
                    end else begin
                        line_sda  = 1'b1;
                        phase     = '0;
                        bit_idx   = '0;
                        finished  = 1'b1;
                        phase_set = 1'b1;
                    end
                end
            endcase
            if (advance_seg)
                load_segment(seg + 1);
            else if (!phase_set)
                phase = phase + 7'd1;
        end
        res.scl       = line_scl;
        res.sda_out   = line_sda;
        res.sda_drive = line_drv;
        res.busy      = (phase != '0);
        res.done      = finished;
        res.rdata     = (finished && is_read) ? read_acc : 16'h0000;
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            dev_addr   = DEV_ADDR_RESET;
            phase      = '0;
            bit_idx    = '0;
            shreg      = '0;
            is_read    = 1'b0;
            reg_latch  = '0;
            data_latch = '0;
            read_acc   = '0;
            line_scl   = 1'b1;
            line_sda   = 1'b1;
            line_drv   = 1'b1;
            fail_count = 0;
            expected_pins.delete();
        end else begin
            if (cfg_write_en)
                dev_addr = cfg_write_data;
            if (out_valid && !out_stall) begin
                got = '{scl, sda_out, sda_drive, busy_res, done_res, read_data};
                if (expected_pins.size() == 0) begin
                    $error("result word arrived with no prediction pending");
                    fail_count++;
                end else begin
                    want = expected_pins.pop_front();
                    check_field("scl", want.scl, got.scl);
                    check_field("sda_out", want.sda_out, got.sda_out);
                    check_field("sda_drive", want.sda_drive, got.sda_drive);
                    check_field("busy_res", want.busy, got.busy);
                    check_field("done_res", want.done, got.done);
                    check_field("read_data", want.rdata, got.rdata);
                end
            end
            if (in_valid && !in_stall) begin
                predict_pin_step(func, reg_addr, write_data, sda_in, predicted);
                expected_pins.push_back(predicted);
            end
        end
    end

endmodule

### verif/tb.sv
// Top of the I2C register master testbench: clock, reset, stimulus and verdict.
// Depends on i2cra_pkg, i2c_register_access_master_unit and i2cra_pin_checker.
module tb;
    import i2cra_pkg::*;

    // Selector value with no meaning; the block treats it as a plain tick.
    localparam logic [1:0] FUNC_SPARE = 2'd3;
    // Pin steps of a full transfer, command word included.
    localparam int WRITE_STEPS = 115;
    localparam int READ_STEPS  = 130;
    localparam int CYCLE_LIMIT = 100000;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [7:0]  cfg_write_data = 8'h00;
    logic        in_valid       = 1'b0;
    logic [1:0]  func           = FUNC_TICK;
    logic [7:0]  reg_addr       = 8'h00;
    logic [15:0] write_data     = 16'h0000;
    logic        sda_in         = 1'b0;
    logic        out_stall      = 1'b0;

    logic        in_stall;
    logic        out_valid;
    logic        scl;
    logic        sda_out;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_data;

    int fail_count;
    int sent_words    = 0;
    int taken_results = 0;
    int cycle_count   = 0;
    int gap_pct       = 0;
    int stall_pct     = 0;

    always #10 clk = ~clk;

    i2c_register_access_master_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .reg_addr       (reg_addr),
        .write_data     (write_data),
        .sda_in         (sda_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .scl            (scl),
        .sda_out        (sda_out),
        .sda_drive      (sda_drive),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .read_data      (read_data)
    );

    i2cra_pin_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .reg_addr       (reg_addr),
        .write_data     (write_data),
        .sda_in         (sda_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .scl            (scl),
        .sda_out        (sda_out),
        .sda_drive      (sda_drive),
        .busy_res       (busy_res),
        .done_res       (done_res),
        .read_data      (read_data),
        .fail_count     (fail_count)
    );

    // Receiver side: stall at random in the share the current phase asks for.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // Count result words taken, so the stimulus can tell when the block has drained.
    always @(posedge clk)
        if (out_valid && !out_stall)
            taken_results <= taken_results + 1;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Offer one word, idling first at random, and hold it until the block takes it.
    task automatic send_word(input logic [1:0] f, input logic [7:0] ra,
                             input logic [15:0] wd, input logic sd);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= f;
        reg_addr   <= ra;
        write_data <= wd;
        sda_in     <= sd;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_words++;
    endtask

    // Drop valid and wait until every word sent has come back as a result.
    task automatic drain();
        in_valid <= 1'b0;
        while (taken_results != sent_words)
            @(posedge clk);
    endtask

    task automatic write_address(input logic [7:0] addr);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= addr;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // One register transfer: the command word, then one tick per pin step.
    // Ticks carry random payload and now and then a stray command, which the
    // busy block must drop. With pause_at set, drain at that step and load a
    // new device address while the transfer is still under way.
    task automatic bus_transfer(input logic rd, input int pause_at, input logic [7:0] pause_addr);
        int         steps;
        int         k;
        logic [7:0] ra;
        logic [15:0] wd;
        logic [1:0] sda_mode;
        logic [1:0] f;
        logic       sd;
        steps = rd ? READ_STEPS : WRITE_STEPS;
        // Cut about one transfer in ten short, so the next command hits a busy bus.
        if (pause_at == 0 && $urandom_range(9) == 0)
            steps = $urandom_range(steps - 1, 1);
        case ($urandom_range(3))
            0:       ra = 8'h00;
            1:       ra = 8'hFF;
            default: ra = 8'($urandom);
        endcase
        case ($urandom_range(3))
            0:       wd = 16'h0000;
            1:       wd = 16'hFFFF;
            default: wd = 16'($urandom);
        endcase
        // Data line seen by the reader: held low, held high, or random per step.
        sda_mode = 2'($urandom_range(3));
        sd = sda_mode[1] ? 1'($urandom_range(1)) : sda_mode[0];
        send_word(rd ? FUNC_READ : FUNC_WRITE, ra, wd, sd);
        for (k = 1; k < steps; k++) begin
            if (k == pause_at) begin
                drain();
                write_address(pause_addr);
            end
            f = FUNC_TICK;
            if ($urandom_range(11) == 0)
                f = 2'($urandom_range(3));
            sd = sda_mode[1] ? 1'($urandom_range(1)) : sda_mode[0];
            send_word(f, 8'($urandom), 16'($urandom), sd);
        end
    endtask

    // A few ticks between transfers, either selector that means no command.
    task automatic idle_words();
        int n;
        int k;
        n = $urandom_range(4);
        for (k = 0; k < n; k++)
            send_word($urandom_range(1) ? FUNC_TICK : FUNC_SPARE, 8'($urandom),
                      16'($urandom), 1'($urandom_range(1)));
    endtask

    // Random transfers until the running word count reaches the mark, then drain.
    task automatic run_phase(input int upto);
        while (sent_words < upto) begin
            idle_words();
            bus_transfer(1'($urandom_range(1)), 0, 8'h00);
        end
        drain();
    endtask

    initial begin
        // sender rarely idles, receiver stalls about half the time
        gap_pct   = 7;
        stall_pct = 52;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Idle ticks with every field at its extremes; the bus must hold its lines.
        send_word(FUNC_TICK, 8'h00, 16'h0000, 1'b0);
        send_word(FUNC_SPARE, 8'hFF, 16'hFFFF, 1'b1);
        send_word(FUNC_TICK, 8'hFF, 16'hFFFF, 1'b1);
        send_word(FUNC_SPARE, 8'h00, 16'h0000, 1'b0);

        // Read at the reset address, then switch to the top address between
        // the first address byte and the read-phase address byte.
        bus_transfer(1'b1, 40, 8'hFE);
        bus_transfer(1'b0, 0, 8'h00);
        run_phase(450);

        // swap: sender idles often, receiver barely stalls
        gap_pct   = 52;
        stall_pct = 7;
        write_address(8'h00);
        run_phase(900);

        // full rate both sides, odd address so the write phase sends bit 0 set
        gap_pct   = 0;
        stall_pct = 0;
        write_address(8'h37);
        run_phase(1320);

        // let any stray result word show up before the verdict
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### sim.f
rtl/core/i2cra_pkg.sv
rtl/core/i2cra_front.sv
rtl/core/i2cra_back.sv
rtl/core/i2c_register_access_master_unit.sv
verif/i2cra_pin_checker.sv
verif/tb.sv
